@@ hdl/bprs_pkg.sv @@
// bprs_pkg: codes, constants and control types for the battery percent
// rescale smoother. No dependencies; used by every file but bprs_if.
`timescale 1ns / 1ps
`default_nettype none
package bprs_pkg;

  localparam int RAW_W = 7;
  localparam int ST_W  = 3;
  localparam int Q_W   = 14;
  localparam int CNT_W = 4;

  localparam logic [RAW_W-1:0] FULL_LIMIT_RESET = 7'd80;
  localparam logic [RAW_W-1:0] FULL_SCALE_RESET = 7'd98;
  localparam logic [RAW_W-1:0] SEARCH_TOP       = 7'd125;
  localparam logic [RAW_W-1:0] PCT_FULL         = 7'd100;
  localparam logic [31:0]      PERIOD_MIN       = 32'd60;
  localparam logic [Q_W-1:0]   DIV_ZERO_Q       = 14'd255;
  localparam logic [Q_W-1:0]   PCT_SCALE        = 14'd100;

  // register indexes on the config port
  localparam logic CFG_FULL_LIMIT = 1'b0;
  localparam logic CFG_FAKE_MODE  = 1'b1;

  // charger status codes
  localparam logic [ST_W-1:0] ST_CHARGING    = 3'd1;
  localparam logic [ST_W-1:0] ST_DISCHARGING = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_CHARGING = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL        = 3'd4;

  // smoothing direction
  localparam logic [1:0] SM_NONE = 2'd0;
  localparam logic [1:0] SM_UP   = 2'd1;
  localparam logic [1:0] SM_DOWN = 2'd2;

  // direction flip
  localparam logic [1:0] CHG_NONE      = 2'd0;
  localparam logic [1:0] CHG_TO_CHARGE = 2'd1;
  localparam logic [1:0] CHG_TO_DISCH  = 2'd2;

  typedef struct packed {
    logic capture;   // latch the input word
    logic bypass;    // fake mode or design unknown: result without state change
    logic learn;     // learn full scale, evaluate direction flip
    logic div_go;    // start a rounded division
    logic div_sel_t; // divisor is the search candidate, else full scale
    logic srch_upd;  // apply one search division result
    logic fix_fs;    // search done, write full scale
    logic commit;    // smoothing step and state update
    logic push;      // move result into the output register
  } bprs_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic fake;
    logic known;
    logic srch_active;
    logic div_done;
    logic out_free;
  } bprs_stat_t;

endpackage
`default_nettype wire

@@ hdl/bprs_if.sv @@
// bprs_if: valid/ready channel interfaces for gauge reports, results and
// config writes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface bprs_in_if;
  logic        valid;
  logic        ready;
  logic [6:0]  gauge_capacity;
  logic [2:0]  charge_status;
  logic        health_good;
  logic [31:0] now_seconds;
  logic        design_known;
  modport source (output valid, gauge_capacity, charge_status, health_good,
                  now_seconds, design_known, input ready);
  modport sink (input valid, gauge_capacity, charge_status, health_good,
                now_seconds, design_known, output ready);
endinterface

interface bprs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] reported_capacity;
  modport source (output valid, reported_capacity, input ready);
  modport sink (input valid, reported_capacity, output ready);
endinterface

interface bprs_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/bprs_div.sv @@
// bprs_div: radix-2 restoring divider for round(raw*100/fs), one quotient
// bit per cycle. Depends on bprs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bprs_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [bprs_pkg::RAW_W-1:0] raw,
  input  wire logic [bprs_pkg::RAW_W-1:0] divisor,
  output logic                           done,
  output logic [bprs_pkg::Q_W-1:0]       q
);
  logic                          busy_r;
  logic                          done_r;
  logic [bprs_pkg::CNT_W-1:0]    cnt_r;
  logic [bprs_pkg::Q_W-1:0]      num_r;
  logic [bprs_pkg::Q_W-1:0]      quo_r;
  logic [bprs_pkg::RAW_W-1:0]    rem_r;
  logic [bprs_pkg::RAW_W-1:0]    dvs_r;
  logic [bprs_pkg::RAW_W:0]      rem_sh;
  logic                          fits;

  assign rem_sh = {rem_r, num_r[bprs_pkg::Q_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= bprs_pkg::CNT_W'(bprs_pkg::Q_W - 1);
        num_r  <= {{(bprs_pkg::Q_W-bprs_pkg::RAW_W){1'b0}}, raw} * bprs_pkg::PCT_SCALE;
        quo_r  <= '0;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        num_r <= {num_r[bprs_pkg::Q_W-2:0], 1'b0};
        quo_r <= {quo_r[bprs_pkg::Q_W-2:0], fits};
        rem_r <= fits ? bprs_pkg::RAW_W'(rem_sh - {1'b0, dvs_r})
                      : rem_sh[bprs_pkg::RAW_W-1:0];
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // round half up on the final remainder
  always_comb begin
    if (dvs_r == '0) q = bprs_pkg::DIV_ZERO_Q;
    else if ({rem_r, 1'b0} >= {1'b0, dvs_r}) q = quo_r + 1'b1;
    else q = quo_r;
  end

  assign done = done_r;
endmodule
`default_nettype wire

@@ hdl/bprs_ctrl.sv @@
// bprs_ctrl: sequencer for one gauge report: learn, full-scale search,
// final rescale, smoothing, output, or bypass. Depends on bprs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bprs_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bprs_pkg::bprs_stat_t  stat,
  output bprs_pkg::bprs_cmd_t        cmd,
  output logic                       in_ready
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_SEARCH, S_SWAIT, S_FDIV, S_FWAIT, S_PUSH
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (stat.in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.fake || !stat.known) begin
          cmd.bypass = 1'b1;
          state_nxt  = S_PUSH;
        end else begin
          cmd.learn = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.srch_active) begin
          cmd.div_go    = 1'b1;
          cmd.div_sel_t = 1'b1;
          state_nxt     = S_SWAIT;
        end else begin
          cmd.fix_fs = 1'b1;
          state_nxt  = S_FDIV;
        end
      end
      S_SWAIT: begin
        if (stat.div_done) begin
          cmd.srch_upd = 1'b1;
          state_nxt    = S_SEARCH;
        end
      end
      S_FDIV: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_FWAIT;
      end
      S_FWAIT: begin
        if (stat.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_PUSH;
        end
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

@@ hdl/bprs_dp.sv @@
// bprs_dp: state registers, config registers, search and smoothing logic,
// output register. Depends on bprs_pkg, bprs_if and bprs_div.
`timescale 1ns / 1ps
`default_nettype none
module bprs_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bprs_pkg::bprs_cmd_t  cmd,
  output bprs_pkg::bprs_stat_t      stat,
  bprs_in_if.sink                   in_ch,
  bprs_out_if.source                out_ch,
  bprs_cfg_if.sink                  cfg_ch
);
  localparam int W = bprs_pkg::RAW_W;

  logic [W-1:0]  full_limit_r;
  logic          fake_mode_r;
  // latched word
  logic [W-1:0]  raw_r;
  logic [2:0]    status_r;
  logic          health_r;
  logic [31:0]   now_r;
  logic          known_r;
  // block state
  logic [W-1:0]  fs_r, fs_nxt;
  logic [2:0]    prev_r, prev_nxt;
  logic [1:0]    smode_r, smode_nxt;
  logic [W-1:0]  shown_r, shown_nxt;
  logic [W-1:0]  lret_r, lret_nxt;
  logic          lret_v_r;
  logic [W-1:0]  lraw_r, lraw_nxt;
  logic          lraw_v_r, lraw_v_nxt;
  logic [31:0]   lraw_t_r, lraw_t_nxt;
  logic [31:0]   lstep_t_r, lstep_t_nxt;
  logic [31:0]   period_r, period_nxt;
  // search
  logic [W-1:0]  t_r, t_nxt;
  logic [1:0]    sdir_r, sdir_nxt;
  logic [1:0]    chg_r, chg_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic          out_valid_r;
  logic [W-1:0]  out_cap_r;

  logic                     div_done;
  logic [bprs_pkg::Q_W-1:0] div_q;
  logic [W-1:0]             lim;
  logic                     learn_hit;
  logic [W-1:0]             fs_l;
  logic [1:0]               chg_c;
  logic                     q_hit;
  logic [W-1:0]             nc, lr, diff, ret, step;
  logic                     changed, due, nc_up;
  logic [31:0]              d, p_new;

  assign cfg_ch.ready = 1'b1;

  bprs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_go),
    .raw     (raw_r),
    .divisor (cmd.div_sel_t ? t_r : fs_r),
    .done    (div_done),
    .q       (div_q)
  );

  assign lim = (full_limit_r == '0) ? W'(1) : full_limit_r;

  always_comb begin
    stat.in_valid    = in_ch.valid;
    stat.fake        = fake_mode_r;
    stat.known       = known_r;
    stat.div_done    = div_done;
    stat.out_free    = !out_valid_r || out_ch.ready;
    stat.srch_active = ((sdir_r == bprs_pkg::SM_UP) && (t_r <= bprs_pkg::SEARCH_TOP)) ||
                       ((sdir_r == bprs_pkg::SM_DOWN) && (t_r >= lim));
  end

  always_comb begin
    learn_hit = ((status_r == bprs_pkg::ST_FULL) ||
                 ((raw_r > fs_r) && (raw_r != bprs_pkg::PCT_FULL))) &&
                health_r && (raw_r > full_limit_r);
    fs_l  = learn_hit ? raw_r : fs_r;
    chg_c = bprs_pkg::CHG_NONE;
    if (prev_r != status_r) begin
      if (((prev_r == bprs_pkg::ST_CHARGING) || (prev_r == bprs_pkg::ST_FULL)) &&
          ((status_r == bprs_pkg::ST_DISCHARGING) ||
           (status_r == bprs_pkg::ST_NOT_CHARGING)))
        chg_c = bprs_pkg::CHG_TO_DISCH;
      else if (((prev_r == bprs_pkg::ST_DISCHARGING) ||
                (prev_r == bprs_pkg::ST_NOT_CHARGING)) &&
               (status_r == bprs_pkg::ST_CHARGING))
        chg_c = bprs_pkg::CHG_TO_CHARGE;
    end
    q_hit = (sdir_r == bprs_pkg::SM_UP) ? (div_q <= {7'd0, shown_r})
                                         : (div_q >= {7'd0, shown_r});
  end

  // smoothing step
  always_comb begin
    if (raw_r < fs_r) nc = (div_q > {7'd0, bprs_pkg::PCT_FULL}) ? bprs_pkg::PCT_FULL
                                                                 : div_q[W-1:0];
    else nc = bprs_pkg::PCT_FULL;
    lr    = lret_v_r ? lret_r : nc;
    nc_up = nc > lr;
    diff  = nc_up ? nc - lr : lr - nc;
    step  = nc_up ? lr + 1'b1 : lr - 1'b1;
    changed = !lraw_v_r || (lraw_r != raw_r);
    if (now_r >= lraw_t_r) d = changed ? now_r - lraw_t_r : now_r - lstep_t_r;
    else d = bprs_pkg::PERIOD_MIN;
    p_new = period_r;
    if (changed && (status_r != bprs_pkg::ST_FULL)) begin
      if (lraw_v_r && (d != '0)) p_new = d;
      if (p_new < bprs_pkg::PERIOD_MIN) p_new = bprs_pkg::PERIOD_MIN;
    end
    due = d >= {1'b0, p_new[31:1]};
    smode_nxt = smode_r;
    if ((status_r == bprs_pkg::ST_DISCHARGING) && nc_up) begin
      ret = lr;
    end else if (diff == W'(1)) begin
      if (smode_r == bprs_pkg::SM_NONE) ret = nc;
      else if (due) begin
        smode_nxt = bprs_pkg::SM_NONE;
        ret = nc;
      end else ret = lr;
    end else if (diff > W'(1)) begin
      if (smode_r == bprs_pkg::SM_NONE) begin
        smode_nxt = nc_up ? bprs_pkg::SM_UP : bprs_pkg::SM_DOWN;
        ret = step;
      end else if (due) ret = step;
      else ret = lr;
    end else begin
      smode_nxt = bprs_pkg::SM_NONE;
      ret = nc;
    end
    if (ret > bprs_pkg::PCT_FULL) ret = bprs_pkg::PCT_FULL;
  end

  always_comb begin
    fs_nxt      = fs_r;
    prev_nxt    = prev_r;
    shown_nxt   = shown_r;
    lret_nxt    = lret_r;
    lraw_nxt    = lraw_r;
    lraw_v_nxt  = lraw_v_r;
    lraw_t_nxt  = lraw_t_r;
    lstep_t_nxt = lstep_t_r;
    period_nxt  = period_r;
    t_nxt       = t_r;
    sdir_nxt    = sdir_r;
    chg_nxt     = chg_r;
    res_nxt     = res_r;
    if (cmd.bypass) res_nxt = fake_mode_r ? raw_r : shown_r;
    if (cmd.learn) begin
      fs_nxt   = fs_l;
      t_nxt    = fs_l;
      prev_nxt = status_r;
      chg_nxt  = chg_c;
      sdir_nxt = bprs_pkg::SM_NONE;
      if ((smode_r == bprs_pkg::SM_UP) && (chg_c == bprs_pkg::CHG_TO_DISCH))
        sdir_nxt = bprs_pkg::SM_UP;
      else if ((smode_r == bprs_pkg::SM_DOWN) && (chg_c == bprs_pkg::CHG_TO_CHARGE))
        sdir_nxt = bprs_pkg::SM_DOWN;
    end
    if (cmd.srch_upd) begin
      if (q_hit) sdir_nxt = bprs_pkg::SM_NONE;
      else if (sdir_r == bprs_pkg::SM_UP) t_nxt = t_r + 1'b1;
      else t_nxt = t_r - 1'b1;
    end
    if (cmd.fix_fs) begin
      fs_nxt = t_r;
      if ((smode_r == bprs_pkg::SM_NONE) && (chg_r == bprs_pkg::CHG_TO_DISCH) &&
          (shown_r == bprs_pkg::PCT_FULL) && (t_r != '0))
        fs_nxt = t_r - 1'b1;
    end
    if (cmd.commit) begin
      if (changed && (status_r != bprs_pkg::ST_FULL)) begin
        period_nxt = p_new;
        lraw_nxt   = raw_r;
        lraw_v_nxt = 1'b1;
        lraw_t_nxt = now_r;
      end
      lret_nxt = ret;
      if (ret != lr) lstep_t_nxt = now_r;
      shown_nxt = ret;
      res_nxt   = ret;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_limit_r <= bprs_pkg::FULL_LIMIT_RESET;
      fake_mode_r  <= 1'b0;
      fs_r         <= bprs_pkg::FULL_SCALE_RESET;
      prev_r       <= '0;
      smode_r      <= bprs_pkg::SM_NONE;
      shown_r      <= '0;
      lret_v_r     <= 1'b0;
      lraw_v_r     <= 1'b0;
      lraw_t_r     <= '0;
      lstep_t_r    <= '0;
      period_r     <= bprs_pkg::PERIOD_MIN;
      sdir_r       <= bprs_pkg::SM_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          bprs_pkg::CFG_FULL_LIMIT: full_limit_r <= cfg_ch.data;
          bprs_pkg::CFG_FAKE_MODE:  fake_mode_r  <= cfg_ch.data[0];
          default: ;
        endcase
      end
      fs_r      <= fs_nxt;
      prev_r    <= prev_nxt;
      shown_r   <= shown_nxt;
      lraw_v_r  <= lraw_v_nxt;
      lraw_t_r  <= lraw_t_nxt;
      lstep_t_r <= lstep_t_nxt;
      period_r  <= period_nxt;
      sdir_r    <= sdir_nxt;
      if (cmd.commit) begin
        smode_r  <= smode_nxt;
        lret_v_r <= 1'b1;
      end
      if (cmd.push) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_r    <= in_ch.gauge_capacity;
      status_r <= in_ch.charge_status;
      health_r <= in_ch.health_good;
      now_r    <= in_ch.now_seconds;
      known_r  <= in_ch.design_known;
    end
    lret_r <= lret_nxt;
    lraw_r <= lraw_nxt;
    t_r    <= t_nxt;
    chg_r  <= chg_nxt;
    res_r  <= res_nxt;
    if (cmd.push) out_cap_r <= res_r;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.reported_capacity = out_cap_r;
endmodule
`default_nettype wire

@@ hdl/battery_percent_rescale_smoother.sv @@
// battery_percent_rescale_smoother: top level, controller plus datapath.
// Depends on bprs_pkg, bprs_if, bprs_div, bprs_ctrl and bprs_dp.
//
// Takes one gauge report at a time and returns one shown percent per report.
// Without a full-scale search a report passes through learn, the final
// rescale division (one quotient bit per cycle) and the smoothing step. A
// search after a charge direction flip adds one division per candidate
// full scale, up to 125 or down to the full limit (1 if it is 0), all
// through the one shared divider. Fake mode and design-unknown reports
// skip learn, search and division. The result sits in an output
// register; the next report is taken once that register is loaded, and a
// result still waiting there holds off the one after it.
`timescale 1ns / 1ps
`default_nettype none
module battery_percent_rescale_smoother (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bprs_in_if.sink    in_ch,
  bprs_out_if.source out_ch,
  bprs_cfg_if.sink   cfg_ch
);
  bprs_pkg::bprs_cmd_t  cmd;
  bprs_pkg::bprs_stat_t stat;
  logic                 in_ready;

  assign in_ch.ready = in_ready;

  bprs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  bprs_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );
endmodule
`default_nettype wire

@@ bench/tb_battery_percent_rescale_smoother.sv @@
// tb_battery_percent_rescale_smoother: self-checking bench for the battery
// percent rescale smoother. Depends on bprs_pkg, bprs_if and the top level.
// Predicts each shown percent in a behavioral model and compares every word.
`timescale 1ns / 1ps
module tb_battery_percent_rescale_smoother;

  localparam logic [bprs_pkg::ST_W-1:0] ST_UNKNOWN = 3'd0;
  // status codes outside the defined set
  localparam logic [bprs_pkg::ST_W-1:0] ST_ODD_5   = 3'd5;
  localparam logic [bprs_pkg::ST_W-1:0] ST_ODD_6   = 3'd6;
  localparam logic [bprs_pkg::ST_W-1:0] ST_ODD_7   = 3'd7;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bprs_in_if  in_ch ();
  bprs_out_if out_ch ();
  bprs_cfg_if cfg_ch ();

  battery_percent_rescale_smoother u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of registers and state
  int unsigned lim_q;
  bit          fake_q;
  int unsigned fs_q, shown_q, last_ret, last_raw, period_q;
  logic [2:0]  prev_st;
  logic [1:0]  sm_dir;
  bit          last_ret_ok, last_raw_ok;
  bit [31:0]   raw_time, step_time;

  logic [6:0] expected_pct[$];
  int errors = 0, words_sent = 0, words_checked = 0, searches = 0, cfg_writes = 0;
  int cycles = 0;
  int hold_left = 0;
  int burst_left = 0;
  bit [31:0] wall = 32'd0;

  function automatic int unsigned round_pct(int unsigned raw, int unsigned fs);
    int unsigned q, r;
    if (fs == 0) return 32'(bprs_pkg::DIV_ZERO_Q);
    q = (raw * 100) / fs;
    r = (raw * 100) % fs;
    if (r * 2 >= fs) q++;
    return q;
  endfunction

  function automatic logic [6:0] predict_shown(logic [6:0] raw, logic [2:0] st, bit hg,
                                               bit [31:0] now, bit known);
    int unsigned rv, t, l, nc, diff, ret;
    logic [1:0] chg;
    bit changed, due;
    bit [31:0] d;
    rv = 32'(raw);
    if (fake_q) return raw;
    if (!known) return shown_q[6:0];
    if ((st == bprs_pkg::ST_FULL || (rv > fs_q && rv != 100)) && hg && rv > lim_q)
      fs_q = rv;
    chg = bprs_pkg::CHG_NONE;
    t = fs_q;
    if (prev_st != st) begin
      if ((prev_st == bprs_pkg::ST_CHARGING || prev_st == bprs_pkg::ST_FULL) &&
          (st == bprs_pkg::ST_DISCHARGING || st == bprs_pkg::ST_NOT_CHARGING))
        chg = bprs_pkg::CHG_TO_DISCH;
      else if ((prev_st == bprs_pkg::ST_DISCHARGING ||
                prev_st == bprs_pkg::ST_NOT_CHARGING) &&
               st == bprs_pkg::ST_CHARGING)
        chg = bprs_pkg::CHG_TO_CHARGE;
      prev_st = st;
    end
    if (sm_dir == bprs_pkg::SM_UP && chg == bprs_pkg::CHG_TO_DISCH) begin
      searches++;
      while (t <= 125 && round_pct(rv, t) > shown_q) t++;
    end else if (sm_dir == bprs_pkg::SM_DOWN && chg == bprs_pkg::CHG_TO_CHARGE) begin
      searches++;
      l = (lim_q == 0) ? 1 : lim_q;
      while (t >= l && round_pct(rv, t) < shown_q) t--;
    end
    fs_q = t & 32'h7f;
    if (sm_dir == bprs_pkg::SM_NONE && chg == bprs_pkg::CHG_TO_DISCH && shown_q == 100 &&
        fs_q > 0)
      fs_q--;
    nc = (rv < fs_q) ? round_pct(rv, fs_q) : 100;
    if (nc > 100) nc = 100;
    // smoothing
    if (!last_ret_ok) begin
      last_ret = nc;
      last_ret_ok = 1'b1;
    end
    diff = (nc > last_ret) ? nc - last_ret : last_ret - nc;
    changed = !last_raw_ok || last_raw != rv;
    if (now >= raw_time) d = changed ? now - raw_time : now - step_time;
    else d = 32'd60;
    if (changed && st != bprs_pkg::ST_FULL) begin
      if (last_raw_ok && d > 0) period_q = d;
      if (period_q < 60) period_q = 60;
      last_raw = rv;
      last_raw_ok = 1'b1;
      raw_time = now;
    end
    if (st == bprs_pkg::ST_DISCHARGING && nc > last_ret) begin
      shown_q = last_ret & 32'h7f;
      return shown_q[6:0];
    end
    due = d >= period_q / 2;
    if (diff == 1) begin
      if (sm_dir == bprs_pkg::SM_NONE) ret = nc;
      else if (due) begin
        sm_dir = bprs_pkg::SM_NONE;
        ret = nc;
      end else ret = last_ret;
    end else if (diff > 1) begin
      if (sm_dir == bprs_pkg::SM_NONE) begin
        sm_dir = (nc > last_ret) ? bprs_pkg::SM_UP : bprs_pkg::SM_DOWN;
        ret = (nc > last_ret) ? last_ret + 1 : last_ret - 1;
      end else if (due) ret = (nc > last_ret) ? last_ret + 1 : last_ret - 1;
      else ret = last_ret;
    end else begin
      sm_dir = bprs_pkg::SM_NONE;
      ret = nc;
    end
    if (ret > 100) ret = 100;
    if (ret != last_ret) begin
      last_ret = ret;
      step_time = now;
    end
    shown_q = ret & 32'h7f;
    return shown_q[6:0];
  endfunction

  // sender: bursts with random gaps, one word per handshake
  // valid stays high between words of a burst and drops at the burst end
  task automatic send_report(logic [6:0] raw, logic [2:0] st, logic hg, logic [31:0] now,
                             logic known);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.gauge_capacity <= raw;
    in_ch.charge_status  <= st;
    in_ch.health_good    <= hg;
    in_ch.now_seconds    <= now;
    in_ch.design_known   <= known;
    do @(posedge clk); while (!in_ch.ready);
    expected_pct.push_back(predict_shown(raw, st, hg, now, known));
    words_sent++;
    @(negedge clk);
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  // typical report: time moves forward, raw drifts
  task automatic send_step(logic [6:0] raw, logic [2:0] st, int unsigned dt);
    wall = wall + dt;
    send_report(raw, st, 1'b1, wall, 1'b1);
  endtask

  task automatic wait_drained();
    if (burst_left != 0) begin
      burst_left = 0;
      in_ch.valid <= 1'b0;
    end
    while (expected_pct.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == bprs_pkg::CFG_FULL_LIMIT) lim_q = 32'(val);
    else fake_q = val[0];
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // receiver: stall pattern with phases of full rate, plus long hold-offs
  initial begin
    int pct;
    pct = 100;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cycles % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: pct = 100;
          1: pct = 70;
          default: pct = 25;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else
        out_ch.ready <= ($urandom_range(1, 100) <= pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pct.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, actual %0d", $time, out_ch.reported_capacity);
      end else begin
        logic [6:0] want;
        want = expected_pct.pop_front();
        words_checked++;
        if (out_ch.reported_capacity !== want) begin
          errors++;
          $display("%0t: reported_capacity expected %0d actual %0d", $time, want,
                   out_ch.reported_capacity);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("battery_percent_rescale_smoother test failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_step(7'd50, bprs_pkg::ST_CHARGING, 0);
    send_step(7'd0, ST_UNKNOWN, 10);
    send_step(7'd100, bprs_pkg::ST_FULL, 10);
    send_step(7'd127, ST_ODD_7, 10);
    send_step(7'd90, bprs_pkg::ST_CHARGING, 100);
    // charge upward smoothing, then flip to discharge: upward search
    send_step(7'd50, bprs_pkg::ST_CHARGING, 100);
    send_step(7'd92, bprs_pkg::ST_CHARGING, 10);
    send_step(7'd91, bprs_pkg::ST_DISCHARGING, 10);
    // downward smoothing, then flip to charge: downward search
    send_step(7'd40, bprs_pkg::ST_DISCHARGING, 100);
    send_step(7'd41, bprs_pkg::ST_CHARGING, 5);
    send_step(7'd85, bprs_pkg::ST_FULL, 200);
    send_step(7'd86, bprs_pkg::ST_DISCHARGING, 200);
    send_report(7'd30, bprs_pkg::ST_CHARGING, 1'b1, wall, 1'b0);      // design unknown
    send_report(7'd60, bprs_pkg::ST_NOT_CHARGING, 1'b0, 32'd1, 1'b1); // clock goes back
    send_report(7'd61, ST_ODD_5, 1'b1, 32'hffff_ffff, 1'b1);
    send_report(7'd99, ST_ODD_6, 1'b1, 32'h0000_0005, 1'b1);
    wall = 32'd5;
    write_reg(bprs_pkg::CFG_FAKE_MODE, 7'd1);
    send_step(7'd127, bprs_pkg::ST_FULL, 3);
    send_step(7'd0, bprs_pkg::ST_DISCHARGING, 3);
    write_reg(bprs_pkg::CFG_FAKE_MODE, 7'd0);
  endtask

  task automatic run_random(int n);
    int raw;
    logic [2:0] st;
    raw = $urandom_range(0, 100);
    st = bprs_pkg::ST_CHARGING;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_report(7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
        wall = in_ch.now_seconds;
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0: st = bprs_pkg::ST_CHARGING;
            1: st = bprs_pkg::ST_DISCHARGING;
            2: st = bprs_pkg::ST_NOT_CHARGING;
            default: st = bprs_pkg::ST_FULL;
          endcase
        end
        if ($urandom_range(0, 9) == 0) raw = $urandom_range(0, 100);
        else raw = raw + (st == bprs_pkg::ST_CHARGING ? 1 : -1) * int'($urandom_range(0, 3));
        if (raw < 0) raw = 0;
        if (raw > 100) raw = 100;
        send_step(7'(raw), st, $urandom_range(0, 120));
      end
    end
  endtask

  task automatic test_config_sweep();
    write_reg(bprs_pkg::CFG_FULL_LIMIT, 7'd1);
    run_random(60);
    write_reg(bprs_pkg::CFG_FULL_LIMIT, 7'd100);
    run_random(50);
    write_reg(bprs_pkg::CFG_FULL_LIMIT, 7'd0);
    run_random(40);
    write_reg(bprs_pkg::CFG_FULL_LIMIT, 7'($urandom_range(40, 99)));
    run_random(60);
    write_reg(bprs_pkg::CFG_FAKE_MODE, 7'd1);
    run_random(15);
    write_reg(bprs_pkg::CFG_FAKE_MODE, 7'd0);
    write_reg(bprs_pkg::CFG_FULL_LIMIT, 7'd127);
    run_random(20);
    write_reg(bprs_pkg::CFG_FULL_LIMIT, bprs_pkg::FULL_LIMIT_RESET);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_left = 300;
    run_random(12);
    // sender pauses until the pipe is empty, then resumes
    wait_drained();
    run_random(10);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.gauge_capacity = '0;
    in_ch.charge_status = '0;
    in_ch.health_good = 1'b0;
    in_ch.now_seconds = '0;
    in_ch.design_known = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = 1'b0;
    cfg_ch.data = '0;
    lim_q = 32'(bprs_pkg::FULL_LIMIT_RESET); fake_q = 1'b0;
    fs_q = 32'(bprs_pkg::FULL_SCALE_RESET); prev_st = '0;
    sm_dir = bprs_pkg::SM_NONE; shown_q = 0;
    last_ret = 101; last_ret_ok = 1'b0; last_raw = 101; last_raw_ok = 1'b0;
    raw_time = '0; step_time = '0; period_q = 60;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    wait_drained();
    $display("covered %0d reports, %0d checked, %0d full-scale searches, %0d register writes",
             words_sent, words_checked, searches, cfg_writes);
    if (errors == 0)
      $display("battery_percent_rescale_smoother test passed");
    else
      $display("battery_percent_rescale_smoother test failed");
    $finish;
  end
endmodule

@@ battery_percent_rescale_smoother.f @@
hdl/bprs_pkg.sv
hdl/bprs_if.sv
hdl/bprs_div.sv
hdl/bprs_ctrl.sv
hdl/bprs_dp.sv
hdl/battery_percent_rescale_smoother.sv
bench/tb_battery_percent_rescale_smoother.sv
